// File: hdl/hsvm_pkg.sv
// shared types, constants and the sine table for the hall sector svm pwm block
// no dependencies
package hsvm_pkg;

  localparam int CNT_BITS    = 16;
  localparam int SINE_LAST   = 60;
  localparam int SIN60_SCALE = 28378;
  localparam int HALF_SIN60  = SIN60_SCALE / 2;
  localparam int DIV_NUM_W   = 30;
  localparam int DIV_DEN_W   = 15;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

  // 2^45 / sin 60 rounded up; the product shifted by 45 gives the exact
  // floor quotient for any numerator below 2^30
  localparam int          RECIP_SHIFT = 45;
  localparam logic [30:0] RECIP_SIN60 = 31'd1239846786;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_DUTY_FULL = 3'd0,
    REG_PERIOD    = 3'd1,
    REG_ADVANCE   = 3'd2,
    REG_PULSE_MIN = 3'd3,
    REG_PULSE_MAX = 3'd4
  } reg_idx_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [14:0] mag;
    logic        neg;
    logic [2:0]  sector;
    logic        invalid;
  } item_t;

  // configuration seen by the back end
  typedef struct packed {
    logic [14:0] full;
    logic [15:0] period;
    logic [4:0]  advance;
    logic [15:0] pulse_min;
    logic [15:0] pulse_max;
  } cfg_t;

  // q15 sine, one entry per degree from 0 to 60
  function automatic logic [14:0] sine_lookup(input logic [5:0] idx);
    logic [14:0] s;
    case (idx)
      6'd0: s = 15'd0;       6'd1: s = 15'd572;     6'd2: s = 15'd1144;
      6'd3: s = 15'd1715;    6'd4: s = 15'd2286;    6'd5: s = 15'd2856;
      6'd6: s = 15'd3425;    6'd7: s = 15'd3993;    6'd8: s = 15'd4560;
      6'd9: s = 15'd5126;    6'd10: s = 15'd5690;   6'd11: s = 15'd6252;
      6'd12: s = 15'd6813;   6'd13: s = 15'd7371;   6'd14: s = 15'd7927;
      6'd15: s = 15'd8481;   6'd16: s = 15'd9032;   6'd17: s = 15'd9580;
      6'd18: s = 15'd10126;  6'd19: s = 15'd10668;  6'd20: s = 15'd11207;
      6'd21: s = 15'd11743;  6'd22: s = 15'd12275;  6'd23: s = 15'd12803;
      6'd24: s = 15'd13328;  6'd25: s = 15'd13848;  6'd26: s = 15'd14365;
      6'd27: s = 15'd14876;  6'd28: s = 15'd15384;  6'd29: s = 15'd15886;
      6'd30: s = 15'd16384;  6'd31: s = 15'd16877;  6'd32: s = 15'd17364;
      6'd33: s = 15'd17847;  6'd34: s = 15'd18324;  6'd35: s = 15'd18795;
      6'd36: s = 15'd19261;  6'd37: s = 15'd19720;  6'd38: s = 15'd20174;
      6'd39: s = 15'd20622;  6'd40: s = 15'd21063;  6'd41: s = 15'd21498;
      6'd42: s = 15'd21926;  6'd43: s = 15'd22348;  6'd44: s = 15'd22763;
      6'd45: s = 15'd23170;  6'd46: s = 15'd23571;  6'd47: s = 15'd23965;
      6'd48: s = 15'd24351;  6'd49: s = 15'd24730;  6'd50: s = 15'd25102;
      6'd51: s = 15'd25466;  6'd52: s = 15'd25822;  6'd53: s = 15'd26170;
      6'd54: s = 15'd26510;  6'd55: s = 15'd26842;  6'd56: s = 15'd27166;
      6'd57: s = 15'd27482;  6'd58: s = 15'd27789;  6'd59: s = 15'd28088;
      6'd60: s = 15'd28378;
      default: s = 15'd28378;
    endcase
    return s;
  endfunction

endpackage

// File: hdl/hsvm_front.sv
// front end: hall decode, duty magnitude saturation and reverse sector shift
// depends on hsvm_pkg
module hsvm_front import hsvm_pkg::*; (
  input  logic        hall_a,
  input  logic        hall_b,
  input  logic        hall_c,
  input  logic [15:0] duty_cycle,
  input  logic [14:0] full,
  output item_t       item
);

  logic [2:0]  code;
  logic [2:0]  sector_fwd;
  logic        invalid;
  logic        neg;
  logic [15:0] mag_raw;

  assign code = {hall_a, hall_b, hall_c};

  // hall code to sector
  always_comb begin
    invalid = 1'b0;
    case (code)
      3'd4: sector_fwd = 3'd0;
      3'd5: sector_fwd = 3'd1;
      3'd1: sector_fwd = 3'd2;
      3'd3: sector_fwd = 3'd3;
      3'd2: sector_fwd = 3'd4;
      3'd6: sector_fwd = 3'd5;
      default: begin
        sector_fwd = 3'd0;
        invalid    = 1'b1;
      end
    endcase
  end

  // magnitude, saturated at full scale
  assign neg     = duty_cycle[15];
  assign mag_raw = neg ? (16'd0 - duty_cycle) : duty_cycle;

  always_comb begin
    item.mag     = (mag_raw > {1'b0, full}) ? full : mag_raw[14:0];
    item.neg     = neg;
    item.invalid = invalid;
    if (neg) begin
      item.sector = (sector_fwd >= 3'd3) ? sector_fwd - 3'd3 : sector_fwd + 3'd3;
    end else begin
      item.sector = sector_fwd;
    end
  end

endmodule

// File: hdl/hsvm_fifo.sv
// short queue between the front and back ends
// depends on hsvm_pkg
module hsvm_fifo import hsvm_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  wr,
  input  item_t wr_item,
  input  logic  rd,
  output item_t rd_item,
  output logic  full,
  output logic  nonempty
);

  item_t              mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic [FIFO_AW:0]   count;

  assign full     = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign nonempty = (count != '0);
  assign rd_item  = mem[rptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr) wptr <= wptr + 1'b1;
      if (rd) rptr <= rptr + 1'b1;
      case ({wr, rd})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (wr) mem[wptr] <= wr_item;
  end

endmodule

// File: hdl/hsvm_div.sv
// pipelined restoring divider, one quotient bit per stage
// depends on hsvm_pkg
module hsvm_div import hsvm_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DIV_NUM_W-1:0] num,
  input  logic [DIV_DEN_W-1:0] den,
  output logic [DIV_NUM_W-1:0] quo
);

  logic [DIV_DEN_W-1:0] rem_q [DIV_NUM_W];
  logic [DIV_NUM_W-1:0] wrd_q [DIV_NUM_W];
  logic [DIV_DEN_W-1:0] den_q [DIV_NUM_W];

  assign quo = wrd_q[DIV_NUM_W-1];

  // each stage shifts in one numerator bit and subtracts where it fits
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < DIV_NUM_W; s++) begin
        logic [DIV_DEN_W-1:0] r_in;
        logic [DIV_NUM_W-1:0] w_in;
        logic [DIV_DEN_W-1:0] d_in;
        logic [DIV_DEN_W:0]   r_sh;
        logic                 ge;
        if (s == 0) begin
          r_in = '0;
          w_in = num;
          d_in = den;
        end else begin
          r_in = rem_q[s-1];
          w_in = wrd_q[s-1];
          d_in = den_q[s-1];
        end
        r_sh     = {r_in, w_in[DIV_NUM_W-1]};
        ge       = (r_sh >= {1'b0, d_in});
        rem_q[s] <= ge ? DIV_DEN_W'(r_sh - {1'b0, d_in}) : r_sh[DIV_DEN_W-1:0];
        wrd_q[s] <= {w_in[DIV_NUM_W-2:0], ge};
        den_q[s] <= d_in;
      end
    end
  end

endmodule

// File: hdl/hsvm_back.sv
// back end: angle, duty ratios, dwell times, edge placement and clamping
// depends on hsvm_pkg and hsvm_div
module hsvm_back import hsvm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        item_valid,
  input  item_t       item,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pulse_a,
  output logic [15:0] pulse_b,
  output logic [15:0] pulse_c,
  output logic [2:0]  sector_used,
  output logic        hall_invalid
);

  typedef struct packed {
    logic [2:0] sector;
    logic       invalid;
    logic       neg;
  } sb_t;

  localparam logic [CNT_BITS-1:0] CNT_MAX = '1;

  logic en;
  assign en  = !out_valid || !out_stall;
  assign pop = en && item_valid;

  // stage 0: numerators for advance and modulation index
  logic                 v0;
  sb_t                  sb0;
  logic [19:0]          adv_num0;
  logic [DIV_NUM_W-1:0] m_num0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (en) begin
      v0 <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb0      <= '{sector: item.sector, invalid: item.invalid, neg: item.neg};
      adv_num0 <= cfg.advance * item.mag;
      m_num0   <= {item.mag, 15'd0} - {15'd0, item.mag} + DIV_NUM_W'(500);
    end
  end

  // first division pass, sideband delayed alongside
  logic [DIV_NUM_W-1:0] adv_q;
  logic [DIV_NUM_W-1:0] m_q;
  logic                 va [DIV_NUM_W];
  sb_t                  sba [DIV_NUM_W];

  hsvm_div u_div_adv (
    .clk (clk), .en (en), .num ({10'd0, adv_num0}), .den (cfg.full), .quo (adv_q)
  );
  hsvm_div u_div_m (
    .clk (clk), .en (en), .num (m_num0), .den (cfg.full), .quo (m_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < DIV_NUM_W; s++) va[s] <= 1'b0;
    end else if (en) begin
      va[0] <= v0;
      for (int s = 1; s < DIV_NUM_W; s++) va[s] <= va[s-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sba[0] <= sb0;
      for (int s = 1; s < DIV_NUM_W; s++) sba[s] <= sba[s-1];
    end
  end

  // stage 1: sine indexes from the angle, clamped to the table
  logic [4:0]  adv;
  logic [5:0]  idx_lo;
  logic [5:0]  idx_hi;
  logic        v1;
  sb_t         sb1;
  logic [15:0] m1;
  logic [5:0]  idx1_1;
  logic [5:0]  idx2_1;

  assign adv    = adv_q[4:0];
  assign idx_lo = (adv > 5'd30) ? 6'd0 : 6'd30 - {1'b0, adv};
  assign idx_hi = ({1'b0, adv} > 6'd30) ? 6'(SINE_LAST) : 6'd30 + {1'b0, adv};

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= va[DIV_NUM_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb1    <= sba[DIV_NUM_W-1];
      m1     <= m_q[15:0];
      idx1_1 <= sba[DIV_NUM_W-1].neg ? idx_hi : idx_lo;
      idx2_1 <= sba[DIV_NUM_W-1].neg ? idx_lo : idx_hi;
    end
  end

  // stage 2: table lookup
  logic        v2;
  sb_t         sb2;
  logic [15:0] m2;
  logic [14:0] s1_2;
  logic [14:0] s2_2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb2  <= sb1;
      m2   <= m1;
      s1_2 <= sine_lookup(idx1_1);
      s2_2 <= sine_lookup(idx2_1);
    end
  end

  // stage 3: products with rounding offset
  logic                 v3;
  sb_t                  sb3;
  logic [DIV_NUM_W-1:0] n1_3;
  logic [DIV_NUM_W-1:0] n2_3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb3  <= sb2;
      n1_3 <= {14'd0, m2} * {15'd0, s1_2} + DIV_NUM_W'(HALF_SIN60);
      n2_3 <= {14'd0, m2} * {15'd0, s2_2} + DIV_NUM_W'(HALF_SIN60);
    end
  end

  // division by sin 60 as a reciprocal product, one stage
  logic [60:0] q1_prod;
  logic [60:0] q2_prod;
  logic        vr;
  sb_t         sbr;
  logic [15:0] t1_q;
  logic [15:0] t2_q;

  assign q1_prod = {31'd0, n1_3} * {30'd0, RECIP_SIN60};
  assign q2_prod = {31'd0, n2_3} * {30'd0, RECIP_SIN60};

  always_ff @(posedge clk) begin
    if (rst) begin
      vr <= 1'b0;
    end else if (en) begin
      vr <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sbr  <= sb3;
      t1_q <= q1_prod[RECIP_SHIFT+15:RECIP_SHIFT];
      t2_q <= q2_prod[RECIP_SHIFT+15:RECIP_SHIFT];
    end
  end

  // stage 4: scale to timer ticks
  logic [31:0] tk1;
  logic [31:0] tk2;
  logic        v4;
  sb_t         sb4;
  logic [16:0] t1_4;
  logic [16:0] t2_4;

  assign tk1 = {16'd0, t1_q} * {16'd0, cfg.period} + 32'd16384;
  assign tk2 = {16'd0, t2_q} * {16'd0, cfg.period} + 32'd16384;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= vr;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb4  <= sbr;
      t1_4 <= tk1[31:15];
      t2_4 <= tk2[31:15];
    end
  end

  // stage 5: zero vector time, floored at zero, halved
  logic signed [18:0] t0;
  logic               v5;
  sb_t                sb5;
  logic [14:0]        h5;
  logic [16:0]        t1_5;
  logic [16:0]        t2_5;

  assign t0 = $signed({3'd0, cfg.period}) - $signed({2'd0, t1_4}) - $signed({2'd0, t2_4});

  always_ff @(posedge clk) begin
    if (rst) begin
      v5 <= 1'b0;
    end else if (en) begin
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb5  <= sb4;
      h5   <= t0[18] ? 15'd0 : t0[15:1];
      t1_5 <= t1_4;
      t2_5 <= t2_4;
    end
  end

  // stage 6: edge placement per sector, saturation and clamp
  function automatic logic [15:0] place(input logic [17:0] v, input cfg_t c);
    logic [15:0] s;
    s = (v > 18'(CNT_MAX)) ? 16'(CNT_MAX) : v[15:0];
    if (s < c.pulse_min) return c.pulse_min;
    if (s > c.pulse_max) return c.pulse_max;
    return s;
  endfunction

  logic [17:0] e_h;
  logic [17:0] e_h1;
  logic [17:0] e_h2;
  logic [17:0] e_all;
  logic [17:0] ea;
  logic [17:0] eb;
  logic [17:0] ec;

  assign e_h   = {3'd0, h5};
  assign e_h1  = e_h + {1'b0, t1_5};
  assign e_h2  = e_h + {1'b0, t2_5};
  assign e_all = e_h1 + {1'b0, t2_5};

  always_comb begin
    case (sb5.sector)
      3'd0: begin ea = e_h2;  eb = e_h;   ec = e_all; end
      3'd1: begin ea = e_all; eb = e_h;   ec = e_h1;  end
      3'd2: begin ea = e_all; eb = e_h2;  ec = e_h;   end
      3'd3: begin ea = e_h1;  eb = e_all; ec = e_h;   end
      3'd4: begin ea = e_h;   eb = e_all; ec = e_h2;  end
      default: begin ea = e_h; eb = e_h2; ec = e_all; end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pulse_a      <= place(ea, cfg);
      pulse_b      <= place(eb, cfg);
      pulse_c      <= place(ec, cfg);
      sector_used  <= sb5.sector;
      hall_invalid <= sb5.invalid;
    end
  end

endmodule

// File: hdl/hall_sector_svm_pwm_core.sv
// throughput: one transaction per cycle; every stage, the 30-stage full-scale
// dividers included, is fully pipelined and only an output stall freezes it
// a four-entry queue separates the input decode from the arithmetic pipeline
// reset: synchronous, clears the queue, pipeline valids and loads register defaults
// depends on hsvm_pkg, hsvm_front, hsvm_fifo, hsvm_back
module hall_sector_svm_pwm_core import hsvm_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        hall_a,
  input  logic        hall_b,
  input  logic        hall_c,
  input  logic signed [15:0] duty_cycle,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] pulse_a,
  output logic [15:0] pulse_b,
  output logic [15:0] pulse_c,
  output logic [2:0]  sector_used,
  output logic        hall_invalid
);

  logic [14:0] duty_full_scale;
  logic [15:0] timer_period;
  logic [4:0]  phase_advance_deg;
  logic [15:0] pulse_min;
  logic [15:0] pulse_max;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      duty_full_scale   <= 15'd1000;
      timer_period      <= 16'd2250;
      phase_advance_deg <= 5'd0;
      pulse_min         <= 16'd10;
      pulse_max         <= 16'd2240;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DUTY_FULL: duty_full_scale   <= cfg_data[14:0];
        REG_PERIOD:    timer_period      <= cfg_data;
        REG_ADVANCE:   phase_advance_deg <= cfg_data[4:0];
        REG_PULSE_MIN: pulse_min         <= cfg_data;
        REG_PULSE_MAX: pulse_max         <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero full scale behaves as one
  cfg_t cfg;
  always_comb begin
    cfg.full      = (duty_full_scale == '0) ? 15'd1 : duty_full_scale;
    cfg.period    = timer_period;
    cfg.advance   = phase_advance_deg;
    cfg.pulse_min = pulse_min;
    cfg.pulse_max = pulse_max;
  end

  // front end and queue
  item_t front_item;
  item_t q_item;
  logic  q_full;
  logic  q_nonempty;
  logic  q_pop;
  logic  accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  hsvm_front u_front (
    .hall_a     (hall_a),
    .hall_b     (hall_b),
    .hall_c     (hall_c),
    .duty_cycle (duty_cycle),
    .full       (cfg.full),
    .item       (front_item)
  );

  hsvm_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr       (accept),
    .wr_item  (front_item),
    .rd       (q_pop),
    .rd_item  (q_item),
    .full     (q_full),
    .nonempty (q_nonempty)
  );

  // arithmetic back end
  hsvm_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .item_valid   (q_nonempty),
    .item         (q_item),
    .pop          (q_pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pulse_a      (pulse_a),
    .pulse_b      (pulse_b),
    .pulse_c      (pulse_c),
    .sector_used  (sector_used),
    .hall_invalid (hall_invalid)
  );

  // result sector always decodes to a real sector
  a_sector_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sector_used <= 3'd5)
    else $error("sector out of range");

  // invalid hall code only yields sector zero or its reverse
  a_invalid_sector: assert property (@(posedge clk) disable iff (rst)
    out_valid && hall_invalid |-> (sector_used == 3'd0 || sector_used == 3'd3))
    else $error("invalid hall code with unexpected sector");

  // pulses stay inside the clamp window when it is well formed
  a_pulse_clamp: assert property (@(posedge clk) disable iff (rst)
    out_valid && (pulse_min <= pulse_max) && !cfg_we |->
      (pulse_a >= pulse_min && pulse_a <= pulse_max &&
       pulse_b >= pulse_min && pulse_b <= pulse_max &&
       pulse_c >= pulse_min && pulse_c <= pulse_max))
    else $error("pulse outside clamp window");

endmodule

// File: tb/tb_hall_sector_svm_pwm_core.sv
// testbench for hall_sector_svm_pwm_core: directed and random drive with a scoreboard
// depends on hsvm_pkg and the core rtl; predicts each transaction from the inputs
module tb_hall_sector_svm_pwm_core;
  import hsvm_pkg::*;

  typedef struct {
    logic [15:0] pa, pb, pc;
    logic [2:0]  sec;
    logic        inv;
  } pulse_set_t;

  // scoreboard: predicts pulse sets and checks results in order
  class pulse_scoreboard;
    pulse_set_t pending[$];
    int errors;
    int checked;
    longint unsigned full, period, adv, pmin, pmax;

    function void load_defaults();
      full = 1000; period = 2250; adv = 0; pmin = 10; pmax = 2240;
    endfunction

    function void write_reg(reg_idx_t idx, logic [15:0] v);
      case (idx)
        REG_DUTY_FULL: full = v[14:0];
        REG_PERIOD:    period = v;
        REG_ADVANCE:   adv = v[4:0];
        REG_PULSE_MIN: pmin = v;
        REG_PULSE_MAX: pmax = v;
        default: ;
      endcase
    endfunction

    function longint unsigned sine_at(longint signed idx);
      if (idx < 0) idx = 0;
      if (idx > SINE_LAST) idx = SINE_LAST;
      return sine_lookup(idx[5:0]);
    endfunction

    function longint unsigned tick_count(longint signed idx, longint unsigned mag,
                                         longint unsigned f);
      longint unsigned m, t;
      m = (mag * 32767 + 500) / f;
      t = (m * sine_at(idx) + HALF_SIN60) / SIN60_SCALE;
      return (t * period + (64'd1 << 14)) >> 15;
    endfunction

    function logic [15:0] clamp_edge(longint unsigned v);
      if (v > 65535) v = 65535;
      if (v < pmin) return pmin[15:0];
      if (v > pmax) return pmax[15:0];
      return v[15:0];
    endfunction

    // note an accepted input transaction
    function void note_input(logic ha, logic hb, logic hc, logic [15:0] raw);
      pulse_set_t e;
      logic neg;
      logic [2:0] code;
      longint unsigned mag, f, t1, t2, h, a, b, c;
      longint signed ang, t0, ad;
      code = {ha, hb, hc};
      neg = raw[15];
      mag = neg ? (65536 - raw) : raw;
      f = (full == 0) ? 1 : full;
      e.inv = 0;
      case (code)
        3'd4: e.sec = 0;
        3'd5: e.sec = 1;
        3'd1: e.sec = 2;
        3'd3: e.sec = 3;
        3'd2: e.sec = 4;
        3'd6: e.sec = 5;
        default: begin
          e.sec = 0; e.inv = 1;
        end
      endcase
      if (mag > f) mag = f;
      ad = (adv * mag) / f;
      ang = neg ? 30 - ad : 30 + ad;
      if (neg) e.sec = (e.sec + 3) % 6;
      t1 = tick_count(60 - ang, mag, f);
      t2 = tick_count(ang, mag, f);
      t0 = longint'(period) - longint'(t1) - longint'(t2);
      if (t0 < 0) t0 = 0;
      h = t0 >> 1;
      case (e.sec)
        0: begin a = h + t2;      b = h;           c = h + t1 + t2; end
        1: begin a = h + t1 + t2; b = h;           c = h + t1;      end
        2: begin a = h + t1 + t2; b = h + t2;      c = h;           end
        3: begin a = h + t1;      b = h + t1 + t2; c = h;           end
        4: begin a = h;           b = h + t1 + t2; c = h + t2;      end
        default: begin a = h;     b = h + t2;      c = h + t1 + t2; end
      endcase
      e.pa = clamp_edge(a); e.pb = clamp_edge(b); e.pc = clamp_edge(c);
      pending.push_back(e);
    endfunction

    function void report(string what, longint unsigned got, longint unsigned want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      errors++;
    endfunction

    // check one accepted result transaction
    function void check_result(pulse_set_t r);
      pulse_set_t e;
      checked++;
      if (pending.size() == 0) begin
        report("result with nothing pending", 0, 0);
        return;
      end
      e = pending.pop_front();
      if (r.pa !== e.pa) report("pulse_a", r.pa, e.pa);
      if (r.pb !== e.pb) report("pulse_b", r.pb, e.pb);
      if (r.pc !== e.pc) report("pulse_c", r.pc, e.pc);
      if (r.sec !== e.sec) report("sector_used", r.sec, e.sec);
      if (r.inv !== e.inv) report("hall_invalid", r.inv, e.inv);
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = 0;
  logic [15:0] cfg_data = 0;
  logic in_valid = 0, in_stall, out_valid, out_stall = 0;
  logic hall_a = 0, hall_b = 0, hall_c = 0;
  logic signed [15:0] duty_cycle = 0;
  logic [15:0] pulse_a, pulse_b, pulse_c;
  logic [2:0] sector_used;
  logic hall_invalid;

  int send_idle_pct = 0, recv_stall_pct = 0;
  logic hold_on = 0;
  int sent = 0;
  pulse_scoreboard sb;

  hall_sector_svm_pwm_core dut (.*);

  always #6 clk = ~clk;

  // receiver: random stall, forced stall during a hold-off
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result('{pulse_a, pulse_b, pulse_c, sector_used, hall_invalid});
    if (hold_on) begin
      out_stall <= 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic write_cfg(reg_idx_t idx, logic [15:0] v);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  // offer one transaction, wait until accepted
  task automatic send_item(logic [2:0] code, logic [15:0] duty);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(posedge clk);
    end
    in_valid <= 1;
    {hall_a, hall_b, hall_c} <= code;
    duty_cycle <= duty;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(code[2], code[1], code[0], duty);
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_duty(longint unsigned f);
    int k;
    k = $urandom_range(9);
    if (k == 0) return 16'($urandom);
    if (k == 1) return 16'h8000;
    if (k < 5) return 16'(f + $urandom_range(3) - 1);
    return $urandom_range(1) ? 16'($urandom_range(f)) : -16'($urandom_range(f));
  endfunction

  task automatic random_phase(int n, int si, int rs);
    send_idle_pct = si; recv_stall_pct = rs;
    repeat (n) send_item(3'($urandom_range(7)), rand_duty(sb.full));
    send_idle_pct = 0; recv_stall_pct = 0;
    drain();
  endtask

  initial begin
    int i;
    sb = new();
    sb.load_defaults();
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: every hall code both directions, duty extremes
    for (i = 0; i < 8; i++) begin
      send_item(3'(i), 16'sd600);
      send_item(3'(i), -16'sd600);
    end
    send_item(3'd4, 16'sd0);
    send_item(3'd5, 16'sd32767);
    send_item(3'd1, 16'h8000);
    send_item(3'd3, -16'sd32767);
    send_item(3'd6, 16'sd1000);
    drain();

    write_cfg(REG_ADVANCE, 16'd30);
    write_cfg(REG_DUTY_FULL, 16'd0);
    send_item(3'd4, 16'sd5);
    send_item(3'd2, -16'sd5);
    drain();
    write_cfg(REG_DUTY_FULL, 16'd1000);
    random_phase(110, 0, 0);

    // narrow period and inverted clamp window
    write_cfg(REG_PERIOD, 16'd1);
    write_cfg(REG_PULSE_MIN, 16'd40);
    write_cfg(REG_PULSE_MAX, 16'd20);
    write_cfg(REG_DUTY_FULL, 16'd1);
    random_phase(110, 85, 0);

    // widest period, full scale and clamps
    write_cfg(REG_PERIOD, 16'hffff);
    write_cfg(REG_DUTY_FULL, 16'd32767);
    write_cfg(REG_ADVANCE, 16'd17);
    write_cfg(REG_PULSE_MIN, 16'd0);
    write_cfg(REG_PULSE_MAX, 16'hffff);
    random_phase(110, 0, 85);

    // long receiver hold-off while the sender keeps offering
    fork
      begin
        hold_on <= 1'b1;
        repeat (300) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
    random_phase(100, 0, 0);

    write_cfg(REG_PERIOD, 16'($urandom_range(65535, 1)));
    write_cfg(REG_DUTY_FULL, 16'($urandom_range(32767, 1)));
    write_cfg(REG_ADVANCE, 16'($urandom_range(31)));
    write_cfg(REG_PULSE_MIN, 16'($urandom_range(200)));
    write_cfg(REG_PULSE_MAX, 16'($urandom_range(65535, 30000)));
    random_phase(100, 30, 30);

    $display("sent %0d transactions over several register setups, %0d results checked",
             sent, sb.checked);
    $display("idle, stall, hold-off, clamp and saturation cases exercised");
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog
  initial begin
    #6000000;
    $display("timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
